FILE: rtl/mtok_pkg.sv
// Shared types and constants for the math expression tokenizer.
// No dependencies; every rtl file refers to it by scoped names.
package mtok_pkg;

  localparam int OFS_BITS    = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = ((2 * OFS_BITS + 7) / 8) * 8;
  localparam int KIND_W      = 4;

  typedef logic [OFS_BITS-1:0] ofs_t;
  localparam ofs_t OFS_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_END        = 4'd0,
    KIND_PLUS       = 4'd1,
    KIND_MINUS      = 4'd2,
    KIND_STAR       = 4'd3,
    KIND_SLASH      = 4'd4,
    KIND_CARET      = 4'd5,
    KIND_UNDERSCORE = 4'd6,
    KIND_COMMA      = 4'd7,
    KIND_LPAREN     = 4'd8,
    KIND_RPAREN     = 4'd9,
    KIND_LCURLY     = 4'd10,
    KIND_RCURLY     = 4'd11,
    KIND_ATOM       = 4'd12,
    KIND_ERROR      = 4'd13
  } kind_t;

  typedef struct packed {
    kind_t kind;
    ofs_t  start_ofs;
    ofs_t  end_ofs;
  } token_t;

  // All tokens caused by one input transaction; tok[0] goes out first.
  typedef struct packed {
    logic [1:0]       cnt;
    token_t [2:0]     tok;
  } bundle_t;

endpackage

FILE: rtl/mtok_front.sv
// Front end: classifies each input character, tracks scanner state and
// builds the bundle of tokens it causes. Depends on mtok_pkg.
module mtok_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_acc,
  input  logic [7:0]                       in_char,
  input  logic                             in_is_end,
  output logic                             push,
  output mtok_pkg::bundle_t                push_bundle
);

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  function automatic mtok_pkg::ofs_t inc_sat(input mtok_pkg::ofs_t v);
    return (v == mtok_pkg::OFS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic is_atom_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || (c == CH_BSLASH);
  endfunction

  function automatic logic is_space_char(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // KIND_END means "not a one-character token"
  function automatic mtok_pkg::kind_t single_kind(input logic [7:0] c);
    mtok_pkg::kind_t k;
    unique case (c)
      CH_PLUS:   k = mtok_pkg::KIND_PLUS;
      CH_MINUS:  k = mtok_pkg::KIND_MINUS;
      CH_STAR:   k = mtok_pkg::KIND_STAR;
      CH_SLASH:  k = mtok_pkg::KIND_SLASH;
      CH_CARET:  k = mtok_pkg::KIND_CARET;
      CH_COMMA:  k = mtok_pkg::KIND_COMMA;
      CH_LPAREN: k = mtok_pkg::KIND_LPAREN;
      CH_RPAREN: k = mtok_pkg::KIND_RPAREN;
      CH_LCURLY: k = mtok_pkg::KIND_LCURLY;
      CH_RCURLY: k = mtok_pkg::KIND_RCURLY;
      default:   k = mtok_pkg::KIND_END;
    endcase
    return k;
  endfunction

  mtok_pkg::ofs_t pos_r, pos_nxt;
  mtok_pkg::ofs_t atom_start_r, atom_start_nxt;
  logic           atom_open_r, atom_open_nxt;
  logic           upend_r, upend_nxt;
  logic           halted_r, halted_nxt;

  mtok_pkg::bundle_t bnd;
  mtok_pkg::kind_t   skind;
  mtok_pkg::ofs_t    p1;
  logic [1:0]        n;

  assign skind = single_kind(in_char);

  always_comb begin
    pos_nxt        = pos_r;
    atom_start_nxt = atom_start_r;
    atom_open_nxt  = atom_open_r;
    upend_nxt      = upend_r;
    halted_nxt     = halted_r;
    bnd            = '0;
    n              = 2'd0;
    p1             = inc_sat(pos_r);
    if (in_acc) begin
      if (in_is_end) begin
        // pending '_' joins the atom, then flush and emit end
        if (upend_r) begin
          if (!atom_open_r) begin
            atom_open_nxt  = 1'b1;
            atom_start_nxt = pos_r;
          end
          pos_nxt = p1;
        end
        if (atom_open_nxt) begin
          bnd.tok[n] = '{mtok_pkg::KIND_ATOM, atom_start_nxt, pos_nxt};
          n = n + 2'd1;
        end
        bnd.tok[n] = '{mtok_pkg::KIND_END, pos_nxt, pos_nxt};
        n = n + 2'd1;
        pos_nxt        = '0;
        atom_start_nxt = '0;
        atom_open_nxt  = 1'b0;
        upend_nxt      = 1'b0;
        halted_nxt     = 1'b0;
      end else if (halted_r) begin
        pos_nxt = p1;
      end else if (upend_r && in_char == CH_LCURLY) begin
        if (atom_open_r) begin
          bnd.tok[n] = '{mtok_pkg::KIND_ATOM, atom_start_r, pos_r};
          n = n + 2'd1;
        end
        bnd.tok[n] = '{mtok_pkg::KIND_UNDERSCORE, pos_r, p1};
        n = n + 2'd1;
        bnd.tok[n] = '{mtok_pkg::KIND_LCURLY, p1, inc_sat(p1)};
        n = n + 2'd1;
        pos_nxt       = inc_sat(p1);
        atom_open_nxt = 1'b0;
        upend_nxt     = 1'b0;
      end else begin
        if (upend_r) begin
          if (!atom_open_r) begin
            atom_open_nxt  = 1'b1;
            atom_start_nxt = pos_r;
          end
          pos_nxt   = p1;
          upend_nxt = 1'b0;
        end
        if (in_char == CH_USCORE) begin
          upend_nxt = 1'b1;
        end else if (is_atom_char(in_char)) begin
          if (!atom_open_nxt) begin
            atom_open_nxt  = 1'b1;
            atom_start_nxt = pos_nxt;
          end
          pos_nxt = inc_sat(pos_nxt);
        end else begin
          if (atom_open_nxt) begin
            bnd.tok[n] = '{mtok_pkg::KIND_ATOM, atom_start_nxt, pos_nxt};
            n = n + 2'd1;
            atom_open_nxt = 1'b0;
          end
          if (skind != mtok_pkg::KIND_END) begin
            bnd.tok[n] = '{skind, pos_nxt, inc_sat(pos_nxt)};
            n = n + 2'd1;
          end else if (!is_space_char(in_char)) begin
            bnd.tok[n] = '{mtok_pkg::KIND_ERROR, pos_nxt, inc_sat(pos_nxt)};
            n = n + 2'd1;
            halted_nxt = 1'b1;
          end
          pos_nxt = inc_sat(pos_nxt);
        end
      end
    end
    bnd.cnt = n;
  end

  assign push        = in_acc && (n != 2'd0);
  assign push_bundle = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      atom_start_r <= '0;
      atom_open_r  <= 1'b0;
      upend_r      <= 1'b0;
      halted_r     <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      atom_start_r <= atom_start_nxt;
      atom_open_r  <= atom_open_nxt;
      upend_r      <= upend_nxt;
      halted_r     <= halted_nxt;
    end
  end

endmodule

FILE: rtl/mtok_queue.sv
// Short bundle queue between the front end and the token serializer.
// Depends on mtok_pkg.
module mtok_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mtok_pkg::bundle_t push_bundle,
  output logic              not_full,
  input  logic              pop,
  output logic              head_valid,
  output mtok_pkg::bundle_t head_bundle
);

  mtok_pkg::bundle_t                  slot_r [mtok_pkg::QUEUE_DEPTH];
  logic [mtok_pkg::QUEUE_AW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [mtok_pkg::QUEUE_CW-1:0]      count_r;

  localparam logic [mtok_pkg::QUEUE_AW-1:0] LAST_PTR =
    mtok_pkg::QUEUE_AW'(mtok_pkg::QUEUE_DEPTH - 1);
  localparam logic [mtok_pkg::QUEUE_CW-1:0] FULL_CNT =
    mtok_pkg::QUEUE_CW'(mtok_pkg::QUEUE_DEPTH);

  assign not_full    = (count_r != FULL_CNT);
  assign head_valid  = (count_r != '0);
  assign head_bundle = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/mtok_back.sv
// Back end: takes bundles from the queue and sends their tokens out one per
// transaction from registers. Depends on mtok_pkg.
module mtok_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  mtok_pkg::bundle_t                   q_bundle,
  output logic                                q_pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mtok_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [mtok_pkg::KIND_W-1:0]         out_tuser,
  output logic                                out_tlast
);

  mtok_pkg::bundle_t cur_r;
  logic [1:0]        idx_r;
  logic              busy_r;
  logic              last;
  logic              out_acc;
  mtok_pkg::token_t  tok;

  assign tok     = cur_r.tok[idx_r];
  assign last    = (idx_r == cur_r.cnt - 2'd1);
  assign out_acc = busy_r && out_tready;
  // refill when idle, or as soon as the final token of the current bundle leaves
  assign q_pop   = q_valid && (!busy_r || (out_acc && last));

  assign out_tvalid = busy_r;
  assign out_tdata  = mtok_pkg::OUT_DATA_W'({tok.end_ofs, tok.start_ofs});
  assign out_tuser  = tok.kind;
  assign out_tlast  = last;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (out_acc && last) begin
      busy_r <= 1'b0;
    end else if (out_acc) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule

FILE: rtl/math_expression_tokenizer_top.sv
// Flow: a token passes through a queue slot and then the back-end cur_r register before out_*.
// Input takes one character per cycle while the queue is not full; tokens leave at
// one per cycle while out_tready is high, so a character that causes several tokens
// holds the output for one transaction per token, and the four-bundle queue absorbs the difference.
// Reset: synchronous active-low rst_n clears offsets, flags, queue and output.
// Top level of the tokenizer; depends on mtok_pkg, mtok_front, mtok_queue, mtok_back.
module math_expression_tokenizer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mtok_pkg::IN_DATA_W-1:0]      in_tdata,   // [7:0] character
  input  logic [0:0]                          in_tuser,   // [0] is_end
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mtok_pkg::OUT_DATA_W-1:0]     out_tdata,  // start_offset, end_offset
  output logic [mtok_pkg::KIND_W-1:0]         out_tuser,  // [3:0] token_kind
  output logic                                out_tlast   // last_of_run
);

  logic              in_acc;
  logic              push;
  logic              q_not_full;
  logic              q_valid;
  logic              q_pop;
  mtok_pkg::bundle_t push_bundle;
  mtok_pkg::bundle_t head_bundle;

  assign in_tready = q_not_full;
  assign in_acc    = in_tvalid && in_tready;

  mtok_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_acc      (in_acc),
    .in_char     (in_tdata[7:0]),
    .in_is_end   (in_tuser[0]),
    .push        (push),
    .push_bundle (push_bundle)
  );

  mtok_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_bundle (push_bundle),
    .not_full    (q_not_full),
    .pop         (q_pop),
    .head_valid  (q_valid),
    .head_bundle (head_bundle)
  );

  mtok_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_bundle   (head_bundle),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/mtok_checker.sv
// Port-level checks on the tokenizer output stream, bound to the top level.
// Depends on mtok_pkg and math_expression_tokenizer_top.
module mtok_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [mtok_pkg::OUT_DATA_W-1:0]     out_tdata,
  input logic [mtok_pkg::KIND_W-1:0]         out_tuser,
  input logic                                out_tlast
);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("out transaction changed while stalled");

  // end token always closes the run of its character
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == mtok_pkg::KIND_END |-> out_tlast)
    else $error("end token without tlast");

  // a token never ends before it starts
  a_ofs_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2*mtok_pkg::OFS_BITS-1:mtok_pkg::OFS_BITS] >=
      out_tdata[mtok_pkg::OFS_BITS-1:0])
    else $error("end offset below start offset");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind math_expression_tokenizer_top mtok_checker u_mtok_checker (.*);

FILE: tb/sv/math_expression_tokenizer_checker.sv
`timescale 1ns / 100ps
// Token checker for math_expression_tokenizer_top: watches both stream channels,
// predicts the tokens of each accepted character and compares them in order.
// Depends on mtok_pkg.
module math_expression_tokenizer_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [mtok_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [0:0]                      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [mtok_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [mtok_pkg::KIND_W-1:0]     out_tuser,
  input  logic                            out_tlast,
  output int                              mismatches,
  output int                              tokens_pending,
  output int                              tokens_checked
);

  typedef struct {
    mtok_pkg::kind_t kind;
    mtok_pkg::ofs_t  start_ofs;
    mtok_pkg::ofs_t  end_ofs;
    logic            last;
  } token_exp_t;

  token_exp_t expected_tokens[$];
  token_exp_t step_tokens[$];

  // scanner state mirror
  mtok_pkg::ofs_t pos;
  mtok_pkg::ofs_t atom_at;
  logic           atom_on;
  logic           us_pend;
  logic           halted;

  int fail_n    = 0;
  int checked_n = 0;

  function automatic mtok_pkg::ofs_t ofs_inc(mtok_pkg::ofs_t v);
    return (v == mtok_pkg::OFS_MAX) ? v : v + mtok_pkg::ofs_t'(1);
  endfunction

  function automatic logic is_atom_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || c == "\\";
  endfunction

  function automatic logic is_space_char(logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic punct_kind(input logic [7:0] c, output mtok_pkg::kind_t k);
    punct_kind = 1'b1;
    k = mtok_pkg::KIND_END;
    case (c)
      "+":     k = mtok_pkg::KIND_PLUS;
      "-":     k = mtok_pkg::KIND_MINUS;
      "*":     k = mtok_pkg::KIND_STAR;
      "/":     k = mtok_pkg::KIND_SLASH;
      "^":     k = mtok_pkg::KIND_CARET;
      ",":     k = mtok_pkg::KIND_COMMA;
      "(":     k = mtok_pkg::KIND_LPAREN;
      ")":     k = mtok_pkg::KIND_RPAREN;
      "{":     k = mtok_pkg::KIND_LCURLY;
      "}":     k = mtok_pkg::KIND_RCURLY;
      default: punct_kind = 1'b0;
    endcase
  endfunction

  task automatic push_token(mtok_pkg::kind_t k, mtok_pkg::ofs_t s, mtok_pkg::ofs_t e);
    token_exp_t t;
    t.kind      = k;
    t.start_ofs = s;
    t.end_ofs   = e;
    t.last      = 1'b0;
    step_tokens = {step_tokens, t};
  endtask

  task automatic close_atom();
    if (atom_on) begin
      push_token(mtok_pkg::KIND_ATOM, atom_at, pos);
      atom_on = 1'b0;
    end
  endtask

  task automatic open_atom();
    if (!atom_on) begin
      atom_on = 1'b1;
      atom_at = pos;
    end
  endtask

  task automatic clear_scanner();
    pos     = '0;
    atom_at = '0;
    atom_on = 1'b0;
    us_pend = 1'b0;
    halted  = 1'b0;
  endtask

  // Tokens caused by one input transaction, appended to expected_tokens.
  task automatic scan_char(input logic [7:0] c, input logic end_mark);
    mtok_pkg::kind_t k;
    logic            pk;
    step_tokens.delete();
    if (end_mark) begin
      if (us_pend) begin
        open_atom();
        us_pend = 1'b0;
        pos = ofs_inc(pos);
      end
      close_atom();
      push_token(mtok_pkg::KIND_END, pos, pos);
      clear_scanner();
    end else if (halted) begin
      pos = ofs_inc(pos);
    end else if (us_pend && c == "{") begin
      us_pend = 1'b0;
      close_atom();
      push_token(mtok_pkg::KIND_UNDERSCORE, pos, ofs_inc(pos));
      pos = ofs_inc(pos);
      push_token(mtok_pkg::KIND_LCURLY, pos, ofs_inc(pos));
      pos = ofs_inc(pos);
    end else begin
      // a held '_' not followed by '{' is part of an atom
      if (us_pend) begin
        us_pend = 1'b0;
        open_atom();
        pos = ofs_inc(pos);
      end
      if (c == "_") begin
        us_pend = 1'b1;
      end else if (is_atom_char(c)) begin
        open_atom();
        pos = ofs_inc(pos);
      end else begin
        close_atom();
        pk = punct_kind(c, k);
        if (pk) begin
          push_token(k, pos, ofs_inc(pos));
        end else if (!is_space_char(c)) begin
          push_token(mtok_pkg::KIND_ERROR, pos, ofs_inc(pos));
          halted = 1'b1;
        end
        pos = ofs_inc(pos);
      end
    end
    if (step_tokens.size() > 0) step_tokens[$].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens = {expected_tokens, step_tokens[i]};
  endtask

  always @(posedge clk) begin
    token_exp_t     want;
    mtok_pkg::ofs_t got_start;
    mtok_pkg::ofs_t got_end;
    if (!rst_n) begin
      clear_scanner();
      expected_tokens.delete();
    end else begin
      if (in_tvalid && in_tready) scan_char(in_tdata, in_tuser[0]);
      if (out_tvalid && out_tready) begin
        got_start = out_tdata[mtok_pkg::OFS_BITS-1:0];
        got_end   = out_tdata[2*mtok_pkg::OFS_BITS-1:mtok_pkg::OFS_BITS];
        if (expected_tokens.size() == 0) begin
          if (fail_n < 10)
            $display("[%0t] token with none expected: kind %0d start %0d end %0d last %0b",
                     $time, out_tuser, got_start, got_end, out_tlast);
          fail_n++;
        end else begin
          want = expected_tokens.pop_front();
          checked_n++;
          if (out_tuser !== want.kind || got_start !== want.start_ofs ||
              got_end !== want.end_ofs || out_tlast !== want.last) begin
            if (fail_n < 10) begin
              $display("[%0t] token mismatch: expected kind %0d start %0d end %0d last %0b",
                       $time, want.kind, want.start_ofs, want.end_ofs, want.last);
              $display("[%0t]                   actual kind %0d start %0d end %0d last %0b",
                       $time, out_tuser, got_start, got_end, out_tlast);
            end
            fail_n++;
          end
        end
      end
    end
    mismatches     <= fail_n;
    tokens_pending <= expected_tokens.size();
    tokens_checked <= checked_n;
  end

endmodule

FILE: tb/sv/math_expression_tokenizer_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for math_expression_tokenizer_top: clock, reset, character
// stimulus with random idling on both channels, watchdog and verdict.
// Depends on mtok_pkg, the tokenizer RTL and math_expression_tokenizer_checker.
module math_expression_tokenizer_top_tb;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 210;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [mtok_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic [0:0]                      in_tuser   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [mtok_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [mtok_pkg::KIND_W-1:0]     out_tuser;
  logic                            out_tlast;

  int mismatches;
  int tokens_pending;
  int tokens_checked;

  int chars_sent  = 0;
  int exprs_sent  = 0;
  int idle_cycles = 0;
  bit calm        = 1'b0;  // no idling on either side

  math_expression_tokenizer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  math_expression_tokenizer_checker token_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatches     (mismatches),
    .tokens_pending (tokens_pending),
    .tokens_checked (tokens_checked)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog: cycles without any transaction on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("math_expression_tokenizer_top regression: fail");
      $finish;
    end
  end

  // Result side backpressure in bursts.
  initial begin
    int n;
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 19);
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      n = $urandom_range(1, 40);
      repeat (n) @(posedge clk);
    end
  end

  task automatic put_item(input logic [7:0] c, input logic end_mark);
    in_tvalid <= 1'b1;
    in_tdata  <= end_mark ? 8'($urandom) : c;  // character is don't-care on end
    in_tuser  <= end_mark;
    do @(posedge clk); while (!in_tready);
    if (end_mark) exprs_sent++;
    else chars_sent++;
  endtask

  task automatic maybe_idle();
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 19);
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) begin
      maybe_idle();
      put_item(s[i], 1'b0);
    end
  endtask

  task automatic send_end();
    maybe_idle();
    put_item(8'h00, 1'b1);
  endtask

  function automatic logic [7:0] atom_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 26) return "a" + 8'(r);
    if (r < 52) return "A" + 8'(r - 26);
    if (r < 62) return "0" + 8'(r - 52);
    if (r == 62) return "\\";
    return "_";
  endfunction

  function automatic logic [7:0] space_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? " " : 8'h09 + 8'(r);
  endfunction

  function automatic logic [7:0] punct_char();
    string ops;
    ops = "+-*/^,(){}";
    return ops[$urandom_range(0, 9)];
  endfunction

  initial begin
    int         rand_chars;
    int         pieces;
    int         len;
    bit         drained;
    bit         broke;

    rand_chars = 0;
    drained    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every token kind, held underscore both ways, whitespace,
    // error after an open atom, halted bytes, end with a held underscore
    send_text("ab_{c} +-*/^,()\t\\Z9_x");
    maybe_idle();
    put_item(8'h0D, 1'b0);
    send_text("q");
    maybe_idle();
    put_item(8'hFF, 1'b0);
    send_text("0");
    send_end();
    send_text("_");
    send_end();
    send_end();
    send_text("_{x} *");
    send_end();

    // random expressions, mostly well formed
    while (rand_chars < RANDOM_ITEMS) begin
      if (!drained && rand_chars >= RANDOM_ITEMS / 2) begin
        drained = 1'b1;
        in_tvalid <= 1'b0;
        do @(posedge clk); while (tokens_pending != 0);
      end
      if (rand_chars >= RANDOM_ITEMS * 4 / 5) calm = 1'b1;
      pieces = $urandom_range(1, 8);
      broke  = 1'b0;
      for (int p = 0; p < pieces && !broke; p++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6: begin
            len = $urandom_range(1, 6);
            for (int j = 0; j < len; j++) begin
              maybe_idle();
              put_item(atom_char(), 1'b0);
            end
            rand_chars += len;
          end
          7, 8, 9, 10, 11: begin
            maybe_idle();
            put_item(punct_char(), 1'b0);
            rand_chars++;
          end
          12, 13, 14: begin
            maybe_idle();
            put_item(space_char(), 1'b0);
            rand_chars++;
          end
          15, 16: begin
            send_text("_{");
            rand_chars += 2;
          end
          17: begin
            // held underscore resolved by a separator
            send_text("_");
            maybe_idle();
            put_item(($urandom_range(0, 1) != 0) ? punct_char() : space_char(), 1'b0);
            rand_chars += 2;
          end
          default: begin
            maybe_idle();
            put_item(8'($urandom_range(0, 255)), 1'b0);
            rand_chars++;
            broke = ($urandom_range(0, 2) != 0);
          end
        endcase
      end
      send_end();
    end

    calm = 1'b1;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tokens_pending != 0);
    repeat (20) @(posedge clk);

    $display("Covered %0d characters in %0d expressions, directed cases and random text.",
             chars_sent, exprs_sent);
    $display("Checked %0d tokens against prediction, %0d mismatches.",
             tokens_checked, mismatches);
    if (mismatches == 0) begin
      $display("math_expression_tokenizer_top regression: pass");
    end else begin
      $display("math_expression_tokenizer_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/mtok_pkg.sv
rtl/mtok_front.sv
rtl/mtok_queue.sv
rtl/mtok_back.sv
rtl/math_expression_tokenizer_top.sv
rtl/mtok_checker.sv
tb/sv/math_expression_tokenizer_checker.sv
tb/sv/math_expression_tokenizer_top_tb.sv
